// ----- design/jed_pkg.sv -----
// Shared types and constants for the JPEG entropy decoder.
// Used by jed_ctrl, jed_dpath and jpeg_entropy_decoder; depends on nothing.
package jed_pkg;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] table_id;
    logic [7:0] slot;
    logic [7:0] payload;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         component;
    logic [3:0]         zero_run;
    logic signed [15:0] coefficient;
    logic               last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic byte_op;
    logic bit_op;
    logic cmp_op;
    logic sym_op;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic byte_bits;
    logic bits_done;
    logic stopped;
    logic code_phase;
    logic cmp_match;
    logic pend_valid;
    logic emit_ok;
  } sts_t;

  // Opcodes.
  localparam logic [1:0] OP_START      = 2'd0;
  localparam logic [1:0] OP_LOAD_COUNT = 2'd1;
  localparam logic [1:0] OP_LOAD_SYM   = 2'd2;
  localparam logic [1:0] OP_DATA       = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_DC    = 3'd0;
  localparam logic [2:0] KIND_AC    = 3'd1;
  localparam logic [2:0] KIND_ZRL   = 3'd2;
  localparam logic [2:0] KIND_EOB   = 3'd3;
  localparam logic [2:0] KIND_EOS   = 3'd4;
  localparam logic [2:0] KIND_ERROR = 3'd5;

  // Decode phases.
  localparam logic [2:0] PH_DC_CODE = 3'd0;
  localparam logic [2:0] PH_DC_BITS = 3'd1;
  localparam logic [2:0] PH_AC_CODE = 3'd2;
  localparam logic [2:0] PH_AC_BITS = 3'd3;
  localparam logic [2:0] PH_STOPPED = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_TAB1  = 2'd1;
  localparam logic [1:0] CFG_TAB2  = 2'd2;
  localparam logic [1:0] CFG_TAB3  = 2'd3;

  // Byte and symbol codes.
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] BYTE_EOI = 8'hD9;
  localparam logic [7:0] SYM_EOB  = 8'h00;
  localparam logic [7:0] SYM_ZRL  = 8'hF0;

  // Fixed widths and limits.
  localparam int         CODE_W    = 16;
  localparam int         FIRST_W   = 25;
  localparam int         OFFS_W    = 13;
  localparam logic [6:0] BLOCK_AC  = 7'd63;
  localparam logic [6:0] ZRL_SPAN  = 7'd16;
  localparam logic [3:0] DC_MAXSZ  = 4'd15;

endpackage

// ----- design/jed_ctrl.sv -----
// Sequencing state machine of the JPEG entropy decoder.
// Depends on jed_pkg for the command and status structs.
module jed_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jed_pkg::sts_t sts,
  output jed_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BYTE  = 3'd1;
  localparam logic [2:0] S_BIT   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_SYM   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0] st_r;
  logic [2:0] st_nxt;

  assign in_ready = (st_r == S_IDLE);

  // Next state and command decode; work that may produce a result waits for room.
  always_comb begin
    cmd    = '0;
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          st_nxt     = S_BYTE;
        end
      end
      S_BYTE: begin
        if (sts.emit_ok) begin
          cmd.byte_op = 1'b1;
          st_nxt      = sts.byte_bits ? S_BIT : S_FLUSH;
        end
      end
      S_BIT: begin
        if (sts.stopped || sts.bits_done) begin
          st_nxt = S_FLUSH;
        end else if (sts.emit_ok) begin
          cmd.bit_op = 1'b1;
          if (sts.code_phase) st_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.emit_ok) begin
          cmd.cmp_op = 1'b1;
          st_nxt     = sts.cmp_match ? S_SYM : S_BIT;
        end
      end
      S_SYM: begin
        if (sts.emit_ok) begin
          cmd.sym_op = 1'b1;
          st_nxt     = S_BIT;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          st_nxt = S_IDLE;
        end else if (sts.emit_ok) begin
          cmd.flush = 1'b1;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end

  // A new transaction is only taken once the previous item's results are handed off.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pend_valid) else $error("pending result while idle");

  // A matched code always continues with the symbol read.
  a_match_to_sym: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cmp_op && sts.cmp_match) |=> (st_r == S_SYM)) else $error("match not followed");

endmodule

// ----- design/jed_dpath.sv -----
// Datapath of the JPEG entropy decoder: Huffman tables, unstuffing, bit-serial
// canonical code matching, value bits and the result registers. Uses jed_pkg.
module jed_dpath #(
  parameter int TC  = 4,
  parameter int MCL = 16,
  parameter int SPT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  jed_pkg::cmd_t     cmd,
  output jed_pkg::sts_t     sts,
  input  jed_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output jed_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [4:0]        cfg_wdata
);

  localparam int CDEPTH = TC * MCL;
  localparam int SDEPTH = TC * SPT;
  localparam int CA_W   = $clog2(CDEPTH);
  localparam int SA_W   = $clog2(SDEPTH);
  localparam int LEN_W  = $clog2(MCL + 1);

  // Configuration registers.
  logic [1:0] ccount_r;
  logic [4:0] ctab1_r, ctab2_r, ctab3_r;

  // Current item and byte shifter.
  jed_pkg::in_item_t item_r;
  logic [7:0] byte_r, byte_nxt;
  logic [3:0] bleft_r, bleft_nxt;

  // Scan state.
  logic [2:0]                   phase_r, phase_nxt;
  logic [1:0]                   comp_r, comp_nxt;
  logic                         aff_r, aff_nxt;
  logic [jed_pkg::CODE_W-1:0]   code_r, code_nxt;
  logic [LEN_W-1:0]             len_r, len_nxt;
  logic [jed_pkg::FIRST_W-1:0]  first_r, first_nxt;
  logic [jed_pkg::OFFS_W-1:0]   offs_r, offs_nxt;
  logic [15:0]                  res_r, res_nxt;
  logic [4:0]                   fill_r, fill_nxt;
  logic [7:0]                   psr_r, psr_nxt;
  logic [6:0]                   cpos_r, cpos_nxt;

  // Result registers: one held result plus the output register.
  jed_pkg::out_item_t pend_r, pend_nxt, out_r, out_nxt;
  logic pendv_r, pendv_nxt, outv_r, outv_nxt;

  // Memories and their read registers.
  logic [7:0]      cnt_mem [CDEPTH];
  logic [CDEPTH-1:0] cnt_vld_r;
  logic [7:0]      sym_mem [SDEPTH];
  logic [7:0]      cnt_rd_r;
  logic            cnt_hit_r;
  logic [7:0]      sym_rd_r;

  // Table selection for the current component.
  logic [4:0] ctab;
  logic [4:0] tbl_num;
  logic       tbl_ok;
  logic       is_dc;
  always_comb begin
    case (comp_r)
      2'd2:    ctab = ctab2_r;
      2'd3:    ctab = ctab3_r;
      default: ctab = ctab1_r;
    endcase
    is_dc   = (phase_r == jed_pkg::PH_DC_CODE);
    tbl_num = is_dc ? {4'd0, ctab[4]} : (5'd2 + {1'b0, ctab[3:0]});
    tbl_ok  = (32'(tbl_num) < TC);
  end

  logic [CA_W-1:0] cnt_raddr, cnt_waddr;
  logic [SA_W-1:0] sym_waddr;
  logic            cnt_we, sym_we;
  assign cnt_raddr = CA_W'(32'(tbl_num) * MCL + 32'(len_r));
  assign cnt_waddr = CA_W'(32'(item_r.table_id) * MCL + 32'(item_r.slot));
  assign sym_waddr = SA_W'(32'(item_r.table_id) * SPT + 32'(item_r.slot));
  assign cnt_we = cmd.byte_op && (item_r.opcode == jed_pkg::OP_LOAD_COUNT) &&
                  (32'(item_r.table_id) < TC) && (32'(item_r.slot) < MCL);
  assign sym_we = cmd.byte_op && (item_r.opcode == jed_pkg::OP_LOAD_SYM) &&
                  (32'(item_r.table_id) < TC) && (32'(item_r.slot) < SPT);

  // Canonical code compare against the count just read.
  logic [7:0]                  cnt;
  logic                        ge;
  logic [15:0]                 diff;
  logic                        in_len;
  logic [jed_pkg::OFFS_W-1:0]  pos;
  logic                        pos_bad;
  logic [SA_W-1:0]             sym_raddr;
  always_comb begin
    cnt       = cnt_hit_r ? cnt_rd_r : 8'd0;
    ge        = ({{(jed_pkg::FIRST_W-jed_pkg::CODE_W){1'b0}}, code_r} >= first_r);
    diff      = code_r - first_r[15:0];
    in_len    = ge && (diff < {8'd0, cnt});
    pos       = offs_r + {{(jed_pkg::OFFS_W-8){1'b0}}, diff[7:0]};
    pos_bad   = (32'(pos) >= SPT);
    sym_raddr = SA_W'(32'(tbl_num) * SPT + 32'(pos));
  end

  // Value bits and sign extension.
  logic [3:0]  vsize;
  logic [15:0] vres;
  logic [4:0]  vfill;
  logic        vdone;
  logic [16:0] vmag, vtmp;
  logic [15:0] vcoef;
  logic        bitv;
  always_comb begin
    bitv  = byte_r[7];
    vsize = (psr_r[3:0] == 4'd0) ? 4'd1 : psr_r[3:0];
    vres  = {res_r[14:0], bitv};
    vfill = fill_r + 5'd1;
    vdone = (vfill >= {1'b0, vsize});
    vmag  = (17'd1 << vsize) - 17'd1;
    vtmp  = {1'b0, vres} - (vres[vsize - 4'd1] ? 17'd0 : vmag);
    vcoef = vtmp[15:0];
  end

  logic [1:0] comp_next_blk;
  assign comp_next_blk = (comp_r >= ccount_r) ? 2'd1 : (comp_r + 2'd1);

  // Scan state update.
  logic               emit_req;
  jed_pkg::out_item_t emit_item;
  logic [6:0]         cpos_sum;
  always_comb begin
    phase_nxt = phase_r;  comp_nxt = comp_r;  aff_nxt = aff_r;
    code_nxt  = code_r;   len_nxt  = len_r;   first_nxt = first_r;
    offs_nxt  = offs_r;   res_nxt  = res_r;   fill_nxt = fill_r;
    psr_nxt   = psr_r;    cpos_nxt = cpos_r;
    byte_nxt  = byte_r;   bleft_nxt = bleft_r;
    emit_req  = 1'b0;
    emit_item = '0;
    emit_item.component = comp_r;
    cpos_sum  = '0;

    if (cmd.byte_op) begin
      case (item_r.opcode)
        jed_pkg::OP_START: begin
          res_nxt = '0; fill_nxt = '0; aff_nxt = 1'b0; comp_nxt = 2'd1;
          psr_nxt = '0; cpos_nxt = '0; phase_nxt = jed_pkg::PH_DC_CODE;
          code_nxt = '0; len_nxt = '0; first_nxt = '0; offs_nxt = '0;
        end
        jed_pkg::OP_DATA: begin
          if (phase_r != jed_pkg::PH_STOPPED) begin
            if (aff_r) begin
              if (item_r.payload == jed_pkg::BYTE_00) begin
                aff_nxt = 1'b0; byte_nxt = jed_pkg::BYTE_FF; bleft_nxt = 4'd8;
              end else if (item_r.payload == jed_pkg::BYTE_EOI) begin
                aff_nxt = 1'b0;
                emit_req = 1'b1;
                emit_item.kind = jed_pkg::KIND_EOS;
                phase_nxt = jed_pkg::PH_STOPPED;
              end else if (item_r.payload != jed_pkg::BYTE_FF) begin
                aff_nxt = 1'b0;
              end
            end else if (item_r.payload == jed_pkg::BYTE_FF) begin
              aff_nxt = 1'b1;
            end else begin
              byte_nxt = item_r.payload; bleft_nxt = 4'd8;
            end
          end
        end
        default: ;
      endcase
    end

    // One scan bit: either a code bit or a value bit.
    if (cmd.bit_op) begin
      byte_nxt  = {byte_r[6:0], 1'b0};
      bleft_nxt = bleft_r - 4'd1;
      if (sts.code_phase) begin
        code_nxt = {code_r[14:0], bitv};
        len_nxt  = len_r + LEN_W'(1);
      end else begin
        res_nxt  = vres;
        fill_nxt = vfill;
        if (vdone) begin
          emit_req = 1'b1;
          emit_item.coefficient = vcoef;
          if (phase_r == jed_pkg::PH_DC_BITS) begin
            emit_item.kind = jed_pkg::KIND_DC;
            cpos_nxt = '0;
            phase_nxt = jed_pkg::PH_AC_CODE;
            code_nxt = '0; len_nxt = '0; first_nxt = '0; offs_nxt = '0;
          end else begin
            emit_item.kind = jed_pkg::KIND_AC;
            emit_item.zero_run = psr_r[7:4];
            cpos_sum = cpos_r + {3'd0, psr_r[7:4]} + 7'd1;
            cpos_nxt = cpos_sum;
            code_nxt = '0; len_nxt = '0; first_nxt = '0; offs_nxt = '0;
            if (cpos_sum >= jed_pkg::BLOCK_AC) begin
              comp_nxt = comp_next_blk; phase_nxt = jed_pkg::PH_DC_CODE;
            end else begin
              phase_nxt = jed_pkg::PH_AC_CODE;
            end
          end
        end
      end
    end

    // Compare the partial code with the current length's code range.
    if (cmd.cmp_op) begin
      if (in_len) begin
        if (pos_bad) begin
          emit_req = 1'b1; emit_item.kind = jed_pkg::KIND_ERROR;
          phase_nxt = jed_pkg::PH_STOPPED;
        end
      end else begin
        offs_nxt  = offs_r + {{(jed_pkg::OFFS_W-8){1'b0}}, cnt};
        first_nxt = (first_r + {{(jed_pkg::FIRST_W-8){1'b0}}, cnt}) << 1;
        if (32'(len_r) >= MCL) begin
          emit_req = 1'b1; emit_item.kind = jed_pkg::KIND_ERROR;
          phase_nxt = jed_pkg::PH_STOPPED;
        end
      end
    end

    // Act on the decoded symbol.
    if (cmd.sym_op) begin
      res_nxt = '0; fill_nxt = '0; psr_nxt = sym_rd_r;
      if (is_dc) begin
        if (sym_rd_r == 8'd0) begin
          emit_req = 1'b1; emit_item.kind = jed_pkg::KIND_DC;
          cpos_nxt = '0; phase_nxt = jed_pkg::PH_AC_CODE;
          code_nxt = '0; len_nxt = '0; first_nxt = '0; offs_nxt = '0;
        end else if (sym_rd_r > {4'd0, jed_pkg::DC_MAXSZ}) begin
          emit_req = 1'b1; emit_item.kind = jed_pkg::KIND_ERROR;
          phase_nxt = jed_pkg::PH_STOPPED;
        end else begin
          phase_nxt = jed_pkg::PH_DC_BITS;
        end
      end else if (sym_rd_r[3:0] == 4'd0) begin
        if (sym_rd_r == jed_pkg::SYM_EOB) begin
          emit_req = 1'b1; emit_item.kind = jed_pkg::KIND_EOB;
          comp_nxt = comp_next_blk; phase_nxt = jed_pkg::PH_DC_CODE;
          code_nxt = '0; len_nxt = '0; first_nxt = '0; offs_nxt = '0;
        end else if (sym_rd_r == jed_pkg::SYM_ZRL) begin
          emit_req = 1'b1; emit_item.kind = jed_pkg::KIND_ZRL;
          cpos_sum = cpos_r + jed_pkg::ZRL_SPAN;
          cpos_nxt = cpos_sum;
          code_nxt = '0; len_nxt = '0; first_nxt = '0; offs_nxt = '0;
          if (cpos_sum >= jed_pkg::BLOCK_AC) begin
            comp_nxt = comp_next_blk; phase_nxt = jed_pkg::PH_DC_CODE;
          end else begin
            phase_nxt = jed_pkg::PH_AC_CODE;
          end
        end else begin
          emit_req = 1'b1; emit_item.kind = jed_pkg::KIND_ERROR;
          phase_nxt = jed_pkg::PH_STOPPED;
        end
      end else begin
        phase_nxt = jed_pkg::PH_AC_BITS;
      end
    end
  end

  // Result staging: a new result pushes the held one out; flush marks the last.
  always_comb begin
    pend_nxt  = pend_r;
    pendv_nxt = pendv_r;
    out_nxt   = out_r;
    outv_nxt  = outv_r && !out_ready;
    if (emit_req) begin
      if (pendv_r) begin
        out_nxt  = pend_r;
        outv_nxt = 1'b1;
      end
      pend_nxt  = emit_item;
      pendv_nxt = 1'b1;
    end else if (cmd.flush) begin
      out_nxt      = pend_r;
      out_nxt.last = 1'b1;
      outv_nxt     = 1'b1;
      pendv_nxt    = 1'b0;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.byte_bits  = (item_r.opcode == jed_pkg::OP_DATA) &&
                     (phase_r != jed_pkg::PH_STOPPED) &&
                     (aff_r ? (item_r.payload == jed_pkg::BYTE_00)
                            : (item_r.payload != jed_pkg::BYTE_FF));
    sts.bits_done  = (bleft_r == 4'd0);
    sts.stopped    = (phase_r == jed_pkg::PH_STOPPED);
    sts.code_phase = (phase_r == jed_pkg::PH_DC_CODE) || (phase_r == jed_pkg::PH_AC_CODE);
    sts.cmp_match  = in_len && !pos_bad;
    sts.pend_valid = pendv_r;
    sts.emit_ok    = !pendv_r || !outv_r || out_ready;
  end

  assign out_valid = outv_r;
  assign out_data  = out_r;

  // Control and scan registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccount_r <= 2'd1;  ctab1_r <= 5'd0;  ctab2_r <= 5'd17;  ctab3_r <= 5'd17;
      phase_r  <= jed_pkg::PH_DC_CODE;  comp_r <= 2'd1;  aff_r <= 1'b0;
      code_r   <= '0;  len_r <= '0;  first_r <= '0;  offs_r <= '0;
      res_r    <= '0;  fill_r <= '0;  psr_r <= '0;  cpos_r <= '0;
      bleft_r  <= '0;  pendv_r <= 1'b0;  outv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          jed_pkg::CFG_COUNT: ccount_r <= cfg_wdata[1:0];
          jed_pkg::CFG_TAB1:  ctab1_r  <= cfg_wdata;
          jed_pkg::CFG_TAB2:  ctab2_r  <= cfg_wdata;
          jed_pkg::CFG_TAB3:  ctab3_r  <= cfg_wdata;
          default: ;
        endcase
      end
      phase_r <= phase_nxt;  comp_r <= comp_nxt;  aff_r <= aff_nxt;
      code_r  <= code_nxt;   len_r  <= len_nxt;   first_r <= first_nxt;
      offs_r  <= offs_nxt;   res_r  <= res_nxt;   fill_r <= fill_nxt;
      psr_r   <= psr_nxt;    cpos_r <= cpos_nxt;  bleft_r <= bleft_nxt;
      pendv_r <= pendv_nxt;  outv_r <= outv_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) item_r <= in_data;
    byte_r <= byte_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // Count valid bits: an unwritten count reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_vld_r <= '0;
    else if (cnt_we) cnt_vld_r[cnt_waddr] <= 1'b1;
  end

  // Count memory: one write, one registered read per scan bit.
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= item_r.payload;
    if (cmd.bit_op) begin
      cnt_rd_r  <= cnt_mem[cnt_raddr];
      cnt_hit_r <= cnt_vld_r[cnt_raddr] && tbl_ok;
    end
  end

  // Symbol memory: one write, one registered read per code compare.
  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_waddr] <= item_r.payload;
    if (cmd.cmp_op) sym_rd_r <= sym_mem[sym_raddr];
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == jed_pkg::PH_DC_BITS) || (phase_r == jed_pkg::PH_AC_BITS)) |->
    (fill_r < 5'd16)) else $error("value bit count overrun");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(len_r) <= MCL)) else $error("code length overrun");

  a_block_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == jed_pkg::PH_AC_CODE) || (phase_r == jed_pkg::PH_AC_BITS)) |->
    (cpos_r < jed_pkg::BLOCK_AC)) else $error("block position overrun");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (outv_r && out_r.last)) else $error("flush did not present last");

endmodule

// ----- design/jpeg_entropy_decoder.sv -----
// Top level of the baseline JPEG Huffman entropy decoder.
// Instantiates jed_ctrl and jed_dpath; types come from jed_pkg.
//
// Items are processed one at a time. A start or table load passes through the
// accept, byte and flush states. A scan data byte is accepted and unstuffed,
// then its eight bits are taken one by one: a Huffman code bit reads the count
// memory and then does the range compare, which also reads the symbol memory,
// with a symbol step when a code completes; a value bit is shifted in alone. A
// byte that gives no bits (a stuffing, fill or marker byte) goes from the byte
// state straight to the flush state. Each step that may produce a result waits
// for room in the result registers. A finished result is held until the next
// pushes it out; an item's last result goes out, marked last, when it completes.
module jpeg_entropy_decoder #(
  parameter int TABLE_COUNT       = 4,
  parameter int MAX_CODE_LENGTH   = 16,
  parameter int SYMBOLS_PER_TABLE = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jed_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jed_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_wdata
);

  jed_pkg::cmd_t cmd;
  jed_pkg::sts_t sts;

  // Sequencer.
  jed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, bit decoding and result registers.
  jed_dpath #(
    .TC  (TABLE_COUNT),
    .MCL (MAX_CODE_LENGTH),
    .SPT (SYMBOLS_PER_TABLE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
